/* design/spes_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spes_pkg - shared types and constants for the seed point edge search
// Frame limits, field widths, the per-pixel record handed from the front end
// to the back end, queue status and register indexes.
// ----------------------------------------------------------------------------
package spes_pkg;

    // largest frame the position counters cover
    localparam int MAX_COLS = 2048;
    localparam int MAX_ROWS = 2048;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    // fixed field widths
    localparam int PIX_W  = 32;
    localparam int SEED_W = 11;
    localparam int SIZE_W = 12;
    localparam int OUT_W  = 11;

    // result packing: four fields, padded to whole bytes
    localparam int OUT_FIELDS_W = 4 * OUT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // compare and sum widths
    localparam int CCMP_W = (COL_W > SEED_W) ? COL_W : SEED_W;
    localparam int RCMP_W = (ROW_W > SEED_W) ? ROW_W : SEED_W;
    localparam int CSUM_W = ((COL_W > OUT_W) ? COL_W : OUT_W) + 1;
    localparam int RSUM_W = ((ROW_W > OUT_W) ? ROW_W : OUT_W) + 1;
    localparam int CSZ_W  = ($clog2(MAX_COLS + 1) > SIZE_W) ? $clog2(MAX_COLS + 1) : SIZE_W;
    localparam int RSZ_W  = ($clog2(MAX_ROWS + 1) > SIZE_W) ? $clog2(MAX_ROWS + 1) : SIZE_W;

    // frame size after reset
    localparam int RST_FRAME_COLS = 1280;
    localparam int RST_FRAME_ROWS = 720;

    // configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = SIZE_W;

    typedef enum logic [CFG_AW-1:0] {
        CFG_SEED_COL   = 2'd0,
        CFG_SEED_ROW   = 2'd1,
        CFG_FRAME_COLS = 2'd2,
        CFG_FRAME_ROWS = 2'd3
    } t_cfg_idx;

    // decoupling queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // one classified pixel
    typedef struct packed {
        logic             first;     // pixel at (0,0): restart edge state
        logic             top_hit;   // marked, seed column, at or above seed
        logic             bot_hit;   // marked, seed column, at or below seed
        logic             left_hit;  // marked, seed row, at or left of seed
        logic             right_hit; // marked, seed row, at or right of seed
        logic             last;      // last pixel of the frame
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_pix_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // last column index for a programmed row length, zero taken as one
    function automatic logic [COL_W-1:0] last_col_of(input logic [SIZE_W-1:0] sz);
        logic [CSZ_W-1:0] w;
        w = CSZ_W'(sz);
        if (w == '0) return '0;
        if (w > CSZ_W'(MAX_COLS)) return COL_W'(MAX_COLS - 1);
        return COL_W'(w - CSZ_W'(1));
    endfunction

    // last row index for a programmed frame height, zero taken as one
    function automatic logic [ROW_W-1:0] last_row_of(input logic [SIZE_W-1:0] sz);
        logic [RSZ_W-1:0] w;
        w = RSZ_W'(sz);
        if (w == '0) return '0;
        if (w > RSZ_W'(MAX_ROWS)) return ROW_W'(MAX_ROWS - 1);
        return ROW_W'(w - RSZ_W'(1));
    endfunction

endpackage
`default_nettype wire

/* design/spes_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spes_front - pixel position tracking and classification
// Keeps the raster position, tags each accepted pixel with its hits against
// the seed row and column and pushes the record into the queue.
// ----------------------------------------------------------------------------
module spes_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_pix_valid,
    input  logic [spes_pkg::PIX_W-1:0]   i_pixel_value,
    input  logic                         i_frame_start,
    input  logic [spes_pkg::SEED_W-1:0]  i_seed_col,
    input  logic [spes_pkg::SEED_W-1:0]  i_seed_row,
    input  logic [spes_pkg::COL_W-1:0]   i_last_col,
    input  logic [spes_pkg::ROW_W-1:0]   i_last_row,
    input  spes_pkg::t_q_stat            i_q_stat,
    output logic                         o_push,
    output spes_pkg::t_pix_rec           o_rec
);

    logic [spes_pkg::COL_W-1:0] r_col, n_col;
    logic [spes_pkg::ROW_W-1:0] r_row, n_row;
    logic [spes_pkg::COL_W-1:0] w_c;
    logic [spes_pkg::ROW_W-1:0] w_r;
    logic                       w_marked;
    logic                       w_on_col;
    logic                       w_on_row;
    logic                       w_accept;

    assign w_accept = i_pix_valid && !i_q_stat.full;
    assign o_push   = w_accept;

    always_comb begin
        // frame start pins this pixel to the origin
        w_c      = i_frame_start ? '0 : r_col;
        w_r      = i_frame_start ? '0 : r_row;
        w_marked = (i_pixel_value != '0) && (i_pixel_value != '1);
        w_on_col = spes_pkg::CCMP_W'(w_c) == spes_pkg::CCMP_W'(i_seed_col);
        w_on_row = spes_pkg::RCMP_W'(w_r) == spes_pkg::RCMP_W'(i_seed_row);

        o_rec.first     = (w_c == '0) && (w_r == '0);
        o_rec.top_hit   = w_marked && w_on_col &&
                          (spes_pkg::RCMP_W'(w_r) <= spes_pkg::RCMP_W'(i_seed_row));
        o_rec.bot_hit   = w_marked && w_on_col &&
                          (spes_pkg::RCMP_W'(w_r) >= spes_pkg::RCMP_W'(i_seed_row));
        o_rec.left_hit  = w_marked && w_on_row &&
                          (spes_pkg::CCMP_W'(w_c) <= spes_pkg::CCMP_W'(i_seed_col));
        o_rec.right_hit = w_marked && w_on_row &&
                          (spes_pkg::CCMP_W'(w_c) >= spes_pkg::CCMP_W'(i_seed_col));
        o_rec.last      = (w_c == i_last_col) && (w_r == i_last_row);
        o_rec.row       = w_r;
        o_rec.col       = w_c;
    end

    // raster advance, wrapping positions left beyond a shrunk frame
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_accept) begin
            if (w_c >= i_last_col) begin
                n_col = '0;
                n_row = (w_r >= i_last_row) ? '0 : w_r + spes_pkg::ROW_W'(1);
            end else if (w_r > i_last_row) begin
                n_col = '0;
                n_row = '0;
            end else begin
                n_col = w_c + spes_pkg::COL_W'(1);
                n_row = w_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule
`default_nettype wire

/* design/spes_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spes_fifo - short record queue between front and back end
// Small register-based fifo; the head is visible while not empty.
// ----------------------------------------------------------------------------
module spes_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  spes_pkg::t_pix_rec i_rec,
    input  logic               i_pop,
    output spes_pkg::t_pix_rec o_head,
    output spes_pkg::t_q_stat  o_stat
);

    spes_pkg::t_pix_rec        r_mem [spes_pkg::Q_DEPTH];
    logic [spes_pkg::Q_AW-1:0] r_wr_ptr;
    logic [spes_pkg::Q_AW-1:0] r_rd_ptr;
    logic [spes_pkg::Q_CW-1:0] r_count;

    assign o_stat.full  = r_count == spes_pkg::Q_CW'(spes_pkg::Q_DEPTH);
    assign o_stat.empty = r_count == '0;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + spes_pkg::Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + spes_pkg::Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + spes_pkg::Q_CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - spes_pkg::Q_CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

/* design/spes_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spes_back - edge tracking and result generation
// Applies each record to the edge state and, on the last pixel of a frame,
// forms the edge and centre values in the output register.
// ----------------------------------------------------------------------------
module spes_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  spes_pkg::t_q_stat                 i_q_stat,
    input  spes_pkg::t_pix_rec                i_rec,
    output logic                              o_pop,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [spes_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);

    logic [spes_pkg::ROW_W-1:0]       r_top, r_bot;
    logic [spes_pkg::COL_W-1:0]       r_left, r_right;
    logic                             r_bot_found, r_right_found;
    logic                             r_out_valid;
    logic [spes_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic [spes_pkg::ROW_W-1:0]       w_top, w_bot, w_bot_sel;
    logic [spes_pkg::COL_W-1:0]       w_left, w_right, w_right_sel;
    logic                             w_bot_found, w_right_found;
    logic                             w_bot_take, w_right_take;
    logic [spes_pkg::CSUM_W-1:0]      w_csum;
    logic [spes_pkg::RSUM_W-1:0]      w_rsum;

    // a frame-end record waits while the output register is held
    assign o_pop      = !i_q_stat.empty && (!i_rec.last || !r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        w_bot_take    = i_rec.bot_hit && !(r_bot_found && !i_rec.first);
        w_right_take  = i_rec.right_hit && !(r_right_found && !i_rec.first);
        w_top         = i_rec.top_hit ? i_rec.row : (i_rec.first ? '0 : r_top);
        w_left        = i_rec.left_hit ? i_rec.col : (i_rec.first ? '0 : r_left);
        w_bot         = w_bot_take ? i_rec.row : r_bot;
        w_right       = w_right_take ? i_rec.col : r_right;
        w_bot_found   = (r_bot_found && !i_rec.first) || w_bot_take;
        w_right_found = (r_right_found && !i_rec.first) || w_right_take;
        // on the last pixel its own position is the far frame edge
        w_bot_sel     = w_bot_found ? w_bot : i_rec.row;
        w_right_sel   = w_right_found ? w_right : i_rec.col;
        w_csum        = spes_pkg::CSUM_W'(w_left) + spes_pkg::CSUM_W'(w_right_sel);
        w_rsum        = spes_pkg::RSUM_W'(w_top) + spes_pkg::RSUM_W'(w_bot_sel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top         <= '0;
            r_bot         <= '0;
            r_left        <= '0;
            r_right       <= '0;
            r_bot_found   <= 1'b0;
            r_right_found <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_top         <= w_top;
                r_bot         <= w_bot;
                r_left        <= w_left;
                r_right       <= w_right;
                r_bot_found   <= w_bot_found;
                r_right_found <= w_right_found;
            end
            if (o_pop && i_rec.last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_rec.last) begin
            r_out_data <= {{spes_pkg::OUT_PAD_W{1'b0}},
                           w_rsum[spes_pkg::OUT_W:1],
                           w_csum[spes_pkg::OUT_W:1],
                           spes_pkg::OUT_W'(w_right_sel),
                           spes_pkg::OUT_W'(w_left)};
        end
    end

endmodule
`default_nettype wire

/* design/seed_point_edge_search_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// seed_point_edge_search_core - nearest marked pixel around a seed point
// Scans a raster stream of label pixels and reports the left and right edge
// columns on the seed row plus the centre column and row once per frame.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 content
//  --------  ---------  ------------------------  -----------------------------
//  s_axis    in         i_s_axis_tvalid/o_tready  one label pixel per request
//  m_axis    out        o_m_axis_tvalid/i_tready  one edge result per frame
//  cfg       in         i_cfg_we                  seed and frame size registers
//
//  one pixel per clock sustained while the queue has room; a frame result is
//  registered behind the queue: its last pixel is pushed into the queue, then
//  the back end pops that record and loads the output register
//  synchronous active-low reset clears position, edge state, queue and result
//  a four-entry queue between front and back end absorbs result stalls; the
//  input request is held off only while that queue is full
//  registers take effect on the next pixel after the write
//
module seed_point_edge_search_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // pixel stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [spes_pkg::PIX_W-1:0]        i_s_axis_tdata,  // [31:0] pixel_value
    input  logic                              i_s_axis_tuser,  // [0] frame_start
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [10:0] left_col, [21:11] right_col, [32:22] center_col,
    // [43:33] center_row, [47:44] zero
    output logic [spes_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // register writes
    input  logic                              i_cfg_we,
    input  logic [spes_pkg::CFG_AW-1:0]       i_cfg_idx,
    input  logic [spes_pkg::CFG_DW-1:0]       i_cfg_wdata
);

    // seed point and effective frame limits (held as last index)
    logic [spes_pkg::SEED_W-1:0] r_seed_col;
    logic [spes_pkg::SEED_W-1:0] r_seed_row;
    logic [spes_pkg::COL_W-1:0]  r_last_col;
    logic [spes_pkg::ROW_W-1:0]  r_last_row;

    // front to queue to back
    logic                        w_push;
    logic                        w_pop;
    spes_pkg::t_pix_rec          w_rec_in;
    spes_pkg::t_pix_rec          w_rec_head;
    spes_pkg::t_q_stat           w_q_stat;

    // register writes; frame sizes are clamped here so the datapath only
    // ever sees a legal last index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_col <= '0;
            r_seed_row <= '0;
            r_last_col <= spes_pkg::last_col_of(spes_pkg::SIZE_W'(spes_pkg::RST_FRAME_COLS));
            r_last_row <= spes_pkg::last_row_of(spes_pkg::SIZE_W'(spes_pkg::RST_FRAME_ROWS));
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                spes_pkg::CFG_SEED_COL: begin
                    r_seed_col <= i_cfg_wdata[spes_pkg::SEED_W-1:0];
                end
                spes_pkg::CFG_SEED_ROW: begin
                    r_seed_row <= i_cfg_wdata[spes_pkg::SEED_W-1:0];
                end
                spes_pkg::CFG_FRAME_COLS: begin
                    r_last_col <= spes_pkg::last_col_of(i_cfg_wdata);
                end
                spes_pkg::CFG_FRAME_ROWS: begin
                    r_last_row <= spes_pkg::last_row_of(i_cfg_wdata);
                end
            endcase
        end
    end

    // accept side ready only depends on queue space
    assign o_s_axis_tready = !w_q_stat.full;

    // position tracking and hit classification
    spes_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix_valid   (i_s_axis_tvalid),
        .i_pixel_value (i_s_axis_tdata),
        .i_frame_start (i_s_axis_tuser),
        .i_seed_col    (r_seed_col),
        .i_seed_row    (r_seed_row),
        .i_last_col    (r_last_col),
        .i_last_row    (r_last_row),
        .i_q_stat      (w_q_stat),
        .o_push        (w_push),
        .o_rec         (w_rec_in)
    );

    // decoupling queue
    spes_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec_in),
        .i_pop   (w_pop),
        .o_head  (w_rec_head),
        .o_stat  (w_q_stat)
    );

    // edge state and result register
    spes_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_stat   (w_q_stat),
        .i_rec      (w_rec_head),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata)
    );

`ifndef SYNTH
    // the queue only fills up behind a frame result that is being held
    a_full_needs_held_result : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid
    ) else $error("pixel queue full without a pending result");

    // a result appears only after a frame-end record left the queue
    a_result_from_frame_end : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_pop && w_rec_head.last)
    ) else $error("result raised without a frame-end pixel");
`endif

endmodule
`default_nettype wire

/* test/seed_point_edge_search_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seed_point_edge_search_core_tb - self-checking bench for the edge search
// Streams label pixel frames into the core under changing seed and frame
// size settings, predicts the per-frame edge result alongside the core and
// compares every result request field by field, with random idling on both
// the pixel and the result side.
// ----------------------------------------------------------------------------
module seed_point_edge_search_core_tb;

    localparam int RANDOM_ITEMS  = 940;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int RUN_LIMIT_NS  = 10_000_000;

    // one result request as it sits in the output word, lowest field last
    typedef struct packed {
        logic [spes_pkg::OUT_W-1:0] center_row;
        logic [spes_pkg::OUT_W-1:0] center_col;
        logic [spes_pkg::OUT_W-1:0] right_col;
        logic [spes_pkg::OUT_W-1:0] left_col;
    } t_bounds;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [spes_pkg::PIX_W-1:0]       s_axis_tdata;   // [31:0] pixel_value
    logic                             s_axis_tuser;   // [0] frame_start
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    // [10:0] left_col, [21:11] right_col, [32:22] center_col,
    // [43:33] center_row, [47:44] zero
    logic [spes_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             cfg_we;
    spes_pkg::t_cfg_idx               cfg_idx;
    logic [spes_pkg::CFG_DW-1:0]      cfg_wdata;

    // mirror of the core registers
    logic [spes_pkg::SEED_W-1:0] seed_col_cfg   = '0;
    logic [spes_pkg::SEED_W-1:0] seed_row_cfg   = '0;
    logic [spes_pkg::SIZE_W-1:0] frame_cols_cfg =
        spes_pkg::SIZE_W'(spes_pkg::RST_FRAME_COLS);
    logic [spes_pkg::SIZE_W-1:0] frame_rows_cfg =
        spes_pkg::SIZE_W'(spes_pkg::RST_FRAME_ROWS);

    // mirror of the scan state
    int  scan_col    = 0;
    int  scan_row    = 0;
    int  top_mark    = 0;
    int  bottom_mark = 0;
    int  left_mark   = 0;
    int  right_mark  = 0;
    bit  bottom_seen = 1'b0;
    bit  right_seen  = 1'b0;

    t_bounds pending_bounds[$];

    int  mismatches  = 0;
    int  pixels_sent = 0;
    int  rx_wait     = 0;
    bit  tx_bursty   = 1'b1;
    bit  rx_bursty   = 1'b1;

    seed_point_edge_search_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // programmed size as the counters see it: zero means one, big saturates
    function automatic int active_size(input logic [spes_pkg::SIZE_W-1:0] sz,
                                       input int max_sz);
        if (sz == '0) return 1;
        if (int'(sz) > max_sz) return max_sz;
        return int'(sz);
    endfunction

    function automatic int frame_pixels();
        return active_size(frame_cols_cfg, spes_pkg::MAX_COLS) *
               active_size(frame_rows_cfg, spes_pkg::MAX_ROWS);
    endfunction

    // one accepted pixel: update the scan mirror, queue a result on the last pixel
    task automatic advance_scan(input logic [spes_pkg::PIX_W-1:0] value, input logic start);
        int      cols;
        int      rows;
        int      c;
        int      r;
        int      bot;
        int      rt;
        bit      hit;
        t_bounds res;
        cols = active_size(frame_cols_cfg, spes_pkg::MAX_COLS);
        rows = active_size(frame_rows_cfg, spes_pkg::MAX_ROWS);
        hit  = (value != '0) && (value != '1);
        if (start) begin
            scan_col = 0;
            scan_row = 0;
        end
        c = scan_col;
        r = scan_row;
        // any pixel at the origin restarts the edge search
        if (c == 0 && r == 0) begin
            top_mark    = 0;
            left_mark   = 0;
            bottom_seen = 1'b0;
            right_seen  = 1'b0;
        end
        if (hit) begin
            if (c == int'(seed_col_cfg)) begin
                if (r <= int'(seed_row_cfg)) top_mark = r;
                if (r >= int'(seed_row_cfg) && !bottom_seen) begin
                    bottom_mark = r;
                    bottom_seen = 1'b1;
                end
            end
            if (r == int'(seed_row_cfg)) begin
                if (c <= int'(seed_col_cfg)) left_mark = c;
                if (c >= int'(seed_col_cfg) && !right_seen) begin
                    right_mark = c;
                    right_seen = 1'b1;
                end
            end
        end
        if (c == cols - 1 && r == rows - 1) begin
            // a search that found nothing stops at the frame edge
            bot = bottom_seen ? bottom_mark : rows - 1;
            rt  = right_seen ? right_mark : cols - 1;
            res.left_col   = spes_pkg::OUT_W'(left_mark);
            res.right_col  = spes_pkg::OUT_W'(rt);
            res.center_col = spes_pkg::OUT_W'((left_mark + rt) >> 1);
            res.center_row = spes_pkg::OUT_W'((top_mark + bot) >> 1);
            pending_bounds.push_back(res);
        end
        // raster advance; a position left outside a shrunk frame wraps
        c++;
        if (c >= cols) begin
            c = 0;
            r++;
            if (r >= rows) r = 0;
        end else if (r >= rows) begin
            r = 0;
            c = 0;
        end
        scan_col = c;
        scan_row = r;
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // result side: ready follows a per-request stall drawn on each accept
    always @(negedge clk) begin
        if (rx_wait > 0) begin
            m_axis_tready <= 1'b0;
            rx_wait       <= rx_wait - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin : check_results
        t_bounds want;
        t_bounds got;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_bounds'(m_axis_tdata[spes_pkg::OUT_FIELDS_W-1:0]);
            if (pending_bounds.size() == 0) begin
                report_mismatch("result with none pending", 1, 0);
            end else begin
                want = pending_bounds.pop_front();
                if (got.left_col != want.left_col)
                    report_mismatch("left_col", got.left_col, want.left_col);
                if (got.right_col != want.right_col)
                    report_mismatch("right_col", got.right_col, want.right_col);
                if (got.center_col != want.center_col)
                    report_mismatch("center_col", got.center_col, want.center_col);
                if (got.center_row != want.center_row)
                    report_mismatch("center_row", got.center_row, want.center_row);
            end
            if (m_axis_tdata[spes_pkg::OUT_TDATA_W-1:spes_pkg::OUT_FIELDS_W] != '0)
                report_mismatch("pad bits",
                    int'(m_axis_tdata[spes_pkg::OUT_TDATA_W-1:spes_pkg::OUT_FIELDS_W]), 0);
            rx_wait <= rx_bursty ? int'($urandom_range(0, 14)) : 0;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one pixel request after a random gap, returns at the accepting edge
    task automatic send_pixel(input logic [spes_pkg::PIX_W-1:0] value, input logic start);
        int gap;
        gap = tx_bursty ? int'($urandom_range(0, 14)) : 0;
        @(negedge clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= start;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        advance_scan(value, start);
        pixels_sent++;
    endtask

    // hold the pixel side until every pending result is back and the core is quiet
    task automatic wait_results_drained();
        int spins;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        spins = 0;
        while (pending_bounds.size() != 0 && spins < DRAIN_LIMIT) begin
            @(negedge clk);
            spins++;
        end
        if (pending_bounds.size() != 0) begin
            report_mismatch("results never arrived", 0, pending_bounds.size());
            pending_bounds.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input spes_pkg::t_cfg_idx idx,
                             input logic [spes_pkg::CFG_DW-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            spes_pkg::CFG_SEED_COL:   seed_col_cfg   = value[spes_pkg::SEED_W-1:0];
            spes_pkg::CFG_SEED_ROW:   seed_row_cfg   = value[spes_pkg::SEED_W-1:0];
            spes_pkg::CFG_FRAME_COLS: frame_cols_cfg = value;
            spes_pkg::CFG_FRAME_ROWS: frame_rows_cfg = value;
        endcase
    endtask

    task automatic set_frame(input logic [spes_pkg::CFG_DW-1:0] cols,
                             input logic [spes_pkg::CFG_DW-1:0] rows,
                             input logic [spes_pkg::CFG_DW-1:0] scol,
                             input logic [spes_pkg::CFG_DW-1:0] srow);
        write_reg(spes_pkg::CFG_FRAME_COLS, cols);
        write_reg(spes_pkg::CFG_FRAME_ROWS, rows);
        write_reg(spes_pkg::CFG_SEED_COL, scol);
        write_reg(spes_pkg::CFG_SEED_ROW, srow);
    endtask

    // density in percent of marked pixels; empty pixels split between 0 and -1
    function automatic logic [spes_pkg::PIX_W-1:0] label_pixel(input int density);
        logic [spes_pkg::PIX_W-1:0] v;
        if (int'($urandom_range(0, 99)) < density) begin
            v = $urandom;
            if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 1) ? 32'h1 : 32'hFFFF_FFFE;
        end else begin
            v = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
        end
        return v;
    endfunction

    task automatic send_frame(input int density, input logic with_start, input int len);
        int i;
        for (i = 0; i < len; i++) send_pixel(label_pixel(density), with_start && i == 0);
    endtask

    // mostly tiny frames, now and then a wider one or a zero size
    function automatic logic [spes_pkg::SIZE_W-1:0] pick_size();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return '0;
        if (pick == 1) return spes_pkg::SIZE_W'($urandom_range(9, 16));
        return spes_pkg::SIZE_W'($urandom_range(1, 8));
    endfunction

    // seed on the first or last position, inside, or beyond the frame;
    // bit 11 is random and must be ignored by the core
    function automatic logic [spes_pkg::CFG_DW-1:0] pick_seed(input int span);
        int pick;
        int s;
        pick = $urandom_range(0, 5);
        case (pick)
            0:       s = 0;
            1:       s = span - 1;
            2:       s = (span < 2048) ? int'($urandom_range(span, 2047))
                                       : int'($urandom_range(0, 2047));
            default: s = $urandom_range(0, span - 1);
        endcase
        return {1'($urandom_range(0, 1)), 11'(s)};
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset settings give no result for a few pixels; then the frame shrinks
    // under a position that lies outside it, which wraps to the next row
    task automatic test_reset_and_resize();
        send_pixel(32'h0000_0005, 1'b1);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h0000_0000, 1'b0);
        wait_results_drained();
        set_frame(12'd2, 12'd2, 12'd1, 12'd1);
        send_pixel(32'h0000_0007, 1'b0);
        send_pixel(32'h1234_5678, 1'b0);
        send_pixel(32'hFFFF_FFFE, 1'b0);
    endtask

    // extreme values, marked and empty, around the seed, and -2 on the seed itself
    task automatic test_marked_values();
        logic [spes_pkg::PIX_W-1:0] grid [9];
        int i;
        grid = '{32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0001,
                 32'h5555_5555, 32'hFFFF_FFFF, 32'hAAAA_AAAA};
        wait_results_drained();
        set_frame(12'd3, 12'd3, 12'd1, 12'd1);
        for (i = 0; i < 9; i++) send_pixel(grid[i], i == 0);
    endtask

    // no marked pixel at all: every search falls back to the frame edge
    task automatic test_empty_frame();
        wait_results_drained();
        set_frame(12'd2, 12'd2, 12'd1, 12'd1);
        send_pixel(32'h0000_0000, 1'b1);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h0000_0000, 1'b0);
    endtask

    // seed beyond the frame is never met, even with every pixel marked
    task automatic test_seed_outside();
        wait_results_drained();
        set_frame(12'd2, 12'd2, 12'hFFF, 12'd3);
        send_pixel(32'h0000_0001, 1'b1);
        send_pixel(32'h0000_0002, 1'b0);
        send_pixel(32'h0000_0003, 1'b0);
        send_pixel(32'h0000_0004, 1'b0);
    endtask

    // second frame relies on the position wrapping after the last pixel
    task automatic test_missing_frame_start();
        wait_results_drained();
        set_frame(12'd1, 12'd2, 12'd0, 12'd1);
        send_pixel(32'h0000_0009, 1'b1);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'hC000_0000, 1'b0);
    endtask

    // zero sizes give one-pixel frames; oversize widths and heights saturate,
    // so a short run of pixels never reaches a frame end
    task automatic test_size_extremes();
        wait_results_drained();
        set_frame(12'd0, 12'd0, 12'd0, 12'd0);
        send_frame(50, 1'b1, 4);
        wait_results_drained();
        set_frame(12'hFFF, 12'd1, 12'd2047, 12'd0);
        send_frame(50, 1'b1, 40);
        wait_results_drained();
        set_frame(12'd1, 12'hFFF, 12'd0, 12'd2047);
        send_frame(50, 1'b1, 40);
    endtask

    // random settings per phase, mostly whole frames, some cut or noisy ones
    task automatic test_random_frames();
        int base;
        int kind;
        int dens;
        int len;
        logic [spes_pkg::SIZE_W-1:0] fc;
        logic [spes_pkg::SIZE_W-1:0] fr;
        base = pixels_sent;
        while (pixels_sent - base < RANDOM_ITEMS) begin
            wait_results_drained();
            fc = pick_size();
            fr = pick_size();
            set_frame(fc, fr, pick_seed(active_size(fc, spes_pkg::MAX_COLS)),
                      pick_seed(active_size(fr, spes_pkg::MAX_ROWS)));
            // stretches without idling on one or both sides
            tx_bursty = $urandom_range(0, 3) != 0;
            rx_bursty = $urandom_range(0, 3) != 0;
            repeat ($urandom_range(1, 4)) begin
                kind = $urandom_range(0, 9);
                dens = $urandom_range(0, 100);
                len  = frame_pixels();
                case (kind)
                    7:       send_frame(dens, 1'b0, len);
                    8:       send_frame(dens, 1'b1, $urandom_range(1, len));
                    9: begin
                        repeat ($urandom_range(1, len))
                            send_pixel(label_pixel(dens), $urandom_range(0, 9) == 0);
                    end
                    default: send_frame(dens, 1'b1, len);
                endcase
                // now and then the sender holds off until all results are back
                if ($urandom_range(0, 7) == 0) wait_results_drained();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = spes_pkg::CFG_SEED_COL;
        cfg_wdata     = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_and_resize();
        test_marked_values();
        test_empty_frame();
        test_seed_outside();
        test_missing_frame_start();
        test_size_extremes();
        test_random_frames();

        wait_results_drained();
        repeat (10) @(negedge clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
design/spes_pkg.sv
design/spes_front.sv
design/spes_fifo.sv
design/spes_back.sv
design/seed_point_edge_search_core.sv
test/seed_point_edge_search_core_tb.sv
